// File: design/ilad_pkg.sv
package ilad_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned SEVMAP_W = 10;
   localparam int unsigned REGIDX_W = 3;

   localparam logic [SEVMAP_W-1:0] SEVMAP_RESET = 10'd768;

   typedef logic [DATA_W-1:0] word_type;
   typedef logic [1:0]        sev_type;

   typedef enum logic [REGIDX_W-1:0] {
      REG_HIHI     = 3'd0,
      REG_HIGH     = 3'd1,
      REG_LOW      = 3'd2,
      REG_LOLO     = 3'd3,
      REG_HYST     = 3'd4,
      REG_SEVMAP   = 3'd5,
      REG_VAL_DB   = 3'd6,
      REG_ARCH_DB  = 3'd7
   } reg_idx_type;

   typedef enum logic [2:0] {
      STAT_NONE = 3'd0,
      STAT_UDF  = 3'd1,
      STAT_LOLO = 3'd2,
      STAT_LOW  = 3'd3,
      STAT_HIGH = 3'd4,
      STAT_HIHI = 3'd5
   } status_type;

   // severity slots in the severity map
   localparam int unsigned SLOT_HIHI = 0;
   localparam int unsigned SLOT_HIGH = 1;
   localparam int unsigned SLOT_LOW  = 2;
   localparam int unsigned SLOT_LOLO = 3;
   localparam int unsigned SLOT_UDF  = 4;

   typedef struct packed {
      word_type              hihi;
      word_type              high;
      word_type              low;
      word_type              lolo;
      word_type              hyst;
      logic [SEVMAP_W-1:0]   sev_map;
      word_type              val_db;
      word_type              arch_db;
   } cfg_type;

   typedef struct packed {
      word_type last_alarm;
      word_type last_posted;
      word_type last_archived;
      logic     undef;
   } state_type;

   typedef struct packed {
      status_type status;
      sev_type    severity;
      logic       post_value;
      logic       post_archive;
   } result_type;

   function automatic sev_type sev_of(input logic [SEVMAP_W-1:0] map, input int unsigned slot);
      sev_of = map[2*slot +: 2];
   endfunction

   function automatic logic upper_hit(input word_type val, input word_type lim,
                                      input word_type last_alarm, input word_type hyst);
      word_type edge_lo;
      edge_lo = lim - hyst;
      upper_hit = ($signed(val) >= $signed(lim)) ||
                  ((last_alarm == lim) && ($signed(val) >= $signed(edge_lo)));
   endfunction

   function automatic logic lower_hit(input word_type val, input word_type lim,
                                      input word_type last_alarm, input word_type hyst);
      word_type edge_hi;
      edge_hi = lim + hyst;
      lower_hit = ($signed(val) <= $signed(lim)) ||
                  ((last_alarm == lim) && ($signed(val) <= $signed(edge_hi)));
   endfunction

   function automatic logic deadband_hit(input word_type last, input word_type val,
                                         input word_type band);
      word_type diff;
      diff = ($signed(last) > $signed(val)) ? (last - val) : (val - last);
      deadband_hit = band[DATA_W-1] || (diff > band);
   endfunction

endpackage

// File: design/ilad_req_if.sv
interface ilad_req_if import ilad_pkg::*;;
   logic     valid;
   logic     ready;
   word_type reading;
   logic     read_ok;

   modport source (output valid, output reading, output read_ok, input ready);
   modport sink   (input valid, input reading, input read_ok, output ready);
endinterface

// File: design/ilad_rsp_if.sv
interface ilad_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] alarm_status;
   logic [1:0] alarm_severity;
   logic       post_value;
   logic       post_archive;

   modport source (output valid, output alarm_status, output alarm_severity,
                   output post_value, output post_archive, input ready);
   modport sink   (input valid, input alarm_status, input alarm_severity,
                   input post_value, input post_archive, output ready);
endinterface

// File: design/ilad_csr_if.sv
interface ilad_csr_if import ilad_pkg::*;;
   logic                valid;
   logic                ready;
   logic [REGIDX_W-1:0] index;
   word_type            data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/ilad_eval.sv
module ilad_eval import ilad_pkg::*; (
   input  word_type   reading,
   input  logic       read_ok,
   input  cfg_type    cfg,
   input  state_type  state,
   output result_type result,
   output state_type  state_next
);

   logic     undef_next;
   sev_type  sev_hihi;
   sev_type  sev_high;
   sev_type  sev_low;
   sev_type  sev_lolo;
   sev_type  sev_udf;
   logic     pv;
   logic     pa;

   always_comb begin
      undef_next = state.undef & ~read_ok;
      sev_hihi   = sev_of(cfg.sev_map, SLOT_HIHI);
      sev_high   = sev_of(cfg.sev_map, SLOT_HIGH);
      sev_low    = sev_of(cfg.sev_map, SLOT_LOW);
      sev_lolo   = sev_of(cfg.sev_map, SLOT_LOLO);
      sev_udf    = sev_of(cfg.sev_map, SLOT_UDF);

      pv = deadband_hit(state.last_posted, reading, cfg.val_db);
      pa = deadband_hit(state.last_archived, reading, cfg.arch_db);

      state_next            = state;
      state_next.undef      = undef_next;
      result.post_value     = pv;
      result.post_archive   = pa;
      result.status         = STAT_NONE;
      result.severity       = '0;

      if (pv) begin
         state_next.last_posted = reading;
      end
      if (pa) begin
         state_next.last_archived = reading;
      end

      if (undef_next) begin
         result.severity = sev_udf;
         result.status   = (sev_udf != '0) ? STAT_UDF : STAT_NONE;
      end else begin
         state_next.last_alarm = reading;
         if (sev_hihi != '0 && upper_hit(reading, cfg.hihi, state.last_alarm, cfg.hyst)) begin
            result.status         = STAT_HIHI;
            result.severity       = sev_hihi;
            state_next.last_alarm = cfg.hihi;
         end else if (sev_lolo != '0 &&
                      lower_hit(reading, cfg.lolo, state.last_alarm, cfg.hyst)) begin
            result.status         = STAT_LOLO;
            result.severity       = sev_lolo;
            state_next.last_alarm = cfg.lolo;
         end else if (sev_high != '0 &&
                      upper_hit(reading, cfg.high, state.last_alarm, cfg.hyst)) begin
            result.status         = STAT_HIGH;
            result.severity       = sev_high;
            state_next.last_alarm = cfg.high;
         end else if (sev_low != '0 &&
                      lower_hit(reading, cfg.low, state.last_alarm, cfg.hyst)) begin
            result.status         = STAT_LOW;
            result.severity       = sev_low;
            state_next.last_alarm = cfg.low;
         end
      end
   end

endmodule

// File: design/integer_limit_alarm_deadband.sv
// path: each item passes the input register, then the result register; a held output stalls it
// throughput: one item per cycle while the output is not stalled; alarm and deadband state
// update in the cycle an item moves from the input register to the result register
// reset: synchronous, active high; clears all state, limits, deadbands and hysteresis to 0,
// severity map to 768 and marks the value undefined
module integer_limit_alarm_deadband import ilad_pkg::*; (
   input logic       clock,
   input logic       reset,
   ilad_req_if.sink  req_ch,
   ilad_rsp_if.source rsp_ch,
   ilad_csr_if.sink  csr_ch
);

   cfg_type    cfg_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;

   logic       in_valid_ff;
   word_type   in_reading_ff;
   logic       in_read_ok_ff;

   logic       out_valid_ff;
   result_type out_result_ff;

   logic       out_load;
   logic       advance;

   assign out_load     = !out_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_load;
   assign req_ch.ready = !in_valid_ff || out_load;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.alarm_status   = out_result_ff.status;
   assign rsp_ch.alarm_severity = out_result_ff.severity;
   assign rsp_ch.post_value     = out_result_ff.post_value;
   assign rsp_ch.post_archive   = out_result_ff.post_archive;

   ilad_eval u_eval (
      .reading    (in_reading_ff),
      .read_ok    (in_read_ok_ff),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .result     (result_in),
      .state_next (state_in)
   );

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hihi    <= '0;
         cfg_ff.high    <= '0;
         cfg_ff.low     <= '0;
         cfg_ff.lolo    <= '0;
         cfg_ff.hyst    <= '0;
         cfg_ff.sev_map <= SEVMAP_RESET;
         cfg_ff.val_db  <= '0;
         cfg_ff.arch_db <= '0;
      end else if (csr_ch.valid) begin
         unique case (reg_idx_type'(csr_ch.index))
            REG_HIHI:    cfg_ff.hihi    <= csr_ch.data;
            REG_HIGH:    cfg_ff.high    <= csr_ch.data;
            REG_LOW:     cfg_ff.low     <= csr_ch.data;
            REG_LOLO:    cfg_ff.lolo    <= csr_ch.data;
            REG_HYST:    cfg_ff.hyst    <= csr_ch.data;
            REG_SEVMAP:  cfg_ff.sev_map <= csr_ch.data[SEVMAP_W-1:0];
            REG_VAL_DB:  cfg_ff.val_db  <= csr_ch.data;
            REG_ARCH_DB: cfg_ff.arch_db <= csr_ch.data;
            default:     cfg_ff         <= cfg_ff;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.valid && req_ch.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_reading_ff <= req_ch.reading;
         in_read_ok_ff <= req_ch.read_ok;
      end
   end

   // alarm and deadband state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.last_alarm    <= '0;
         state_ff.last_posted   <= '0;
         state_ff.last_archived <= '0;
         state_ff.undef         <= 1'b1;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= result_in;
      end
   end

endmodule

// File: tb/tb_integer_limit_alarm_deadband.sv
module tb_integer_limit_alarm_deadband;
   import ilad_pkg::*;

   typedef struct {
      bit          is_cfg;
      reg_idx_type idx;
      word_type    value;
      logic        ok;
      bit          typed;
      result_type  want;
   } dir_row_type;

   logic clock;
   logic reset;

   ilad_req_if req_if();
   ilad_rsp_if rsp_if();
   ilad_csr_if csr_if();

   integer_limit_alarm_deadband u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // shadow of the block's registers and alarm state
   cfg_type    csr_shadow;
   word_type   alarm_level;
   word_type   posted_value;
   word_type   archived_value;
   logic       in_undefined;

   result_type  alarm_expect_q[$];
   dir_row_type dir_rows[$];
   int          mismatches = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   function automatic logic crosses_up(input word_type val, input word_type lim);
      word_type band_edge;
      band_edge = lim - csr_shadow.hyst;
      if ($signed(val) >= $signed(lim)) return 1'b1;
      return (alarm_level == lim) && ($signed(val) >= $signed(band_edge));
   endfunction

   function automatic logic crosses_down(input word_type val, input word_type lim);
      word_type band_edge;
      band_edge = lim + csr_shadow.hyst;
      if ($signed(val) <= $signed(lim)) return 1'b1;
      return (alarm_level == lim) && ($signed(val) <= $signed(band_edge));
   endfunction

   function automatic logic outside_deadband(input word_type last, input word_type val,
                                             input word_type band);
      word_type diff;
      if (band[DATA_W-1]) return 1'b1;
      if ($signed(last) > $signed(val)) diff = last - val;
      else diff = val - last;
      return diff > band;
   endfunction

   function automatic result_type alarm_predict(input word_type val, input logic ok);
      result_type r;
      word_type   lvl;
      sev_type    s_hihi, s_high, s_low, s_lolo;
      s_hihi = csr_shadow.sev_map[2*SLOT_HIHI +: 2];
      s_high = csr_shadow.sev_map[2*SLOT_HIGH +: 2];
      s_low  = csr_shadow.sev_map[2*SLOT_LOW +: 2];
      s_lolo = csr_shadow.sev_map[2*SLOT_LOLO +: 2];
      r.status = STAT_NONE;
      r.severity = '0;
      if (ok) in_undefined = 1'b0;
      if (in_undefined) begin
         r.severity = csr_shadow.sev_map[2*SLOT_UDF +: 2];
         if (r.severity != '0) r.status = STAT_UDF;
      end else begin
         lvl = val;
         if (s_hihi != '0 && crosses_up(val, csr_shadow.hihi)) begin
            r.status = STAT_HIHI; r.severity = s_hihi; lvl = csr_shadow.hihi;
         end else if (s_lolo != '0 && crosses_down(val, csr_shadow.lolo)) begin
            r.status = STAT_LOLO; r.severity = s_lolo; lvl = csr_shadow.lolo;
         end else if (s_high != '0 && crosses_up(val, csr_shadow.high)) begin
            r.status = STAT_HIGH; r.severity = s_high; lvl = csr_shadow.high;
         end else if (s_low != '0 && crosses_down(val, csr_shadow.low)) begin
            r.status = STAT_LOW; r.severity = s_low; lvl = csr_shadow.low;
         end
         alarm_level = lvl;
      end
      r.post_value = outside_deadband(posted_value, val, csr_shadow.val_db);
      if (r.post_value) posted_value = val;
      r.post_archive = outside_deadband(archived_value, val, csr_shadow.arch_db);
      if (r.post_archive) archived_value = val;
      return r;
   endfunction

   task automatic write_reg(input reg_idx_type idx, input word_type value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      case (idx)
         REG_HIHI:    csr_shadow.hihi = value;
         REG_HIGH:    csr_shadow.high = value;
         REG_LOW:     csr_shadow.low = value;
         REG_LOLO:    csr_shadow.lolo = value;
         REG_HYST:    csr_shadow.hyst = value;
         REG_SEVMAP:  csr_shadow.sev_map = value[SEVMAP_W-1:0];
         REG_VAL_DB:  csr_shadow.val_db = value;
         REG_ARCH_DB: csr_shadow.arch_db = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // valid is left high after a transfer so back-to-back items need no gap
   task automatic send_reading(input word_type val, input logic ok, input bit typed,
                               input result_type typed_want);
      result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.reading <= val;
      req_if.read_ok <= ok;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      r = alarm_predict(val, ok);
      alarm_expect_q.push_back(typed ? typed_want : r);
   endtask

   task automatic drain;
      req_if.valid <= 1'b0;
      while (alarm_expect_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic word_type edge_word;
      case ($urandom_range(3))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         default: return 32'hffff_ffff;
      endcase
   endfunction

   function automatic word_type small_band;
      if ($urandom_range(3) == 0) return word_type'(0) - word_type'($urandom_range(1, 5));
      return word_type'($urandom_range(0, 30));
   endfunction

   task automatic pick_config(input int mode);
      word_type c, s1, s2;
      word_type v[8];
      if (mode == 0) begin
         if ($urandom_range(3) == 0) c = word_type'($urandom_range(0, 400)) + 32'h7fff_ff38;
         else c = word_type'($urandom_range(0, 2000)) - 1000;
         s1 = $urandom_range(1, 100);
         s2 = $urandom_range(1, 100);
         v[REG_HIHI] = c + s1 + s2;
         v[REG_HIGH] = c + s1;
         v[REG_LOW]  = c - s1;
         v[REG_LOLO] = c - s1 - s2;
         if ($urandom_range(3) == 0) begin
            v[REG_HIGH] = c - s1 - s2;
            v[REG_LOLO] = c + s1;
         end
         v[REG_HYST]    = small_band();
         v[REG_SEVMAP]  = $urandom_range(0, 1023);
         v[REG_VAL_DB]  = small_band();
         v[REG_ARCH_DB] = small_band();
      end else if (mode == 1) begin
         foreach (v[i]) v[i] = edge_word();
         v[REG_SEVMAP] = $urandom_range(1) ? 32'h3ff : 32'h0;
      end else begin
         foreach (v[i]) v[i] = $urandom();
         v[REG_SEVMAP] = $urandom_range(0, 1023);
      end
      write_reg(REG_HIHI, v[REG_HIHI]);
      write_reg(REG_HIGH, v[REG_HIGH]);
      write_reg(REG_LOW, v[REG_LOW]);
      write_reg(REG_LOLO, v[REG_LOLO]);
      write_reg(REG_HYST, v[REG_HYST]);
      write_reg(REG_SEVMAP, v[REG_SEVMAP]);
      write_reg(REG_VAL_DB, v[REG_VAL_DB]);
      write_reg(REG_ARCH_DB, v[REG_ARCH_DB]);
   endtask

   // readings cluster around the limits and band edges so holds and clears happen
   function automatic word_type pick_reading;
      word_type base;
      case ($urandom_range(15))
         0, 1: return $urandom();
         2:    return edge_word();
         3, 4: base = csr_shadow.hihi;
         5, 6: base = csr_shadow.lolo;
         7, 8: base = csr_shadow.high;
         9, 10: base = csr_shadow.low;
         11:   base = csr_shadow.hihi - csr_shadow.hyst;
         12:   base = csr_shadow.lolo + csr_shadow.hyst;
         13:   base = csr_shadow.high - csr_shadow.hyst;
         default: base = csr_shadow.low + csr_shadow.hyst;
      endcase
      return base + word_type'($urandom_range(0, 8)) - 4;
   endfunction

   task automatic add_cfg(input reg_idx_type idx, input word_type value);
      dir_row_type row;
      row.is_cfg = 1'b1; row.idx = idx; row.value = value;
      row.ok = 1'b0; row.typed = 1'b0; row.want = '0;
      dir_rows.push_back(row);
   endtask

   task automatic add_item(input word_type value, input logic ok);
      dir_row_type row;
      row.is_cfg = 1'b0; row.idx = REG_HIHI; row.value = value;
      row.ok = ok; row.typed = 1'b0; row.want = '0;
      dir_rows.push_back(row);
   endtask

   task automatic add_typed(input word_type value, input logic ok, input status_type st,
                            input sev_type sv, input logic pv, input logic pa);
      dir_row_type row;
      row.is_cfg = 1'b0; row.idx = REG_HIHI; row.value = value;
      row.ok = ok; row.typed = 1'b1;
      row.want.status = st; row.want.severity = sv;
      row.want.post_value = pv; row.want.post_archive = pa;
      dir_rows.push_back(row);
   endtask

   always @(posedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (alarm_expect_q.size() == 0) begin
            report_mismatch($sformatf("result with no pending item, status %0d",
                                      rsp_if.alarm_status));
         end else begin
            want = alarm_expect_q.pop_front();
            if (rsp_if.alarm_status !== want.status)
               report_mismatch($sformatf("alarm_status got %0d want %0d",
                                         rsp_if.alarm_status, want.status));
            if (rsp_if.alarm_severity !== want.severity)
               report_mismatch($sformatf("alarm_severity got %0d want %0d",
                                         rsp_if.alarm_severity, want.severity));
            if (rsp_if.post_value !== want.post_value)
               report_mismatch($sformatf("post_value got %0b want %0b",
                                         rsp_if.post_value, want.post_value));
            if (rsp_if.post_archive !== want.post_archive)
               report_mismatch($sformatf("post_archive got %0b want %0b",
                                         rsp_if.post_archive, want.post_archive));
         end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.reading <= '0;
      req_if.read_ok <= 1'b0;
      csr_if.valid   <= 1'b0;
      csr_if.index   <= REG_HIHI;
      csr_if.data    <= '0;

      csr_shadow         = '0;
      csr_shadow.sev_map = SEVMAP_RESET;
      alarm_level        = '0;
      posted_value       = '0;
      archived_value     = '0;
      in_undefined       = 1'b1;

      // undefined with default and zero severity, then the limit bands
      add_typed(32'd5, 1'b0, STAT_UDF, 2'd3, 1'b1, 1'b1);
      add_typed(32'd5, 1'b0, STAT_UDF, 2'd3, 1'b0, 1'b0);
      add_cfg(REG_SEVMAP, 32'h0);
      add_typed(-32'sd7, 1'b0, STAT_NONE, 2'd0, 1'b1, 1'b1);
      add_cfg(REG_SEVMAP, 32'h296);
      add_typed(32'd3, 1'b0, STAT_UDF, 2'd2, 1'b1, 1'b1);
      add_cfg(REG_HIHI, 32'd100);
      add_cfg(REG_HIGH, 32'd50);
      add_cfg(REG_LOW, -32'sd50);
      add_cfg(REG_LOLO, -32'sd100);
      add_cfg(REG_HYST, 32'd10);
      add_cfg(REG_VAL_DB, 32'd20);
      add_cfg(REG_ARCH_DB, 32'd40);
      add_item(32'd0, 1'b1);
      add_item(32'd100, 1'b0);
      add_item(32'd95, 1'b1);
      add_item(32'd89, 1'b1);
      add_item(32'd45, 1'b0);
      add_item(32'd39, 1'b1);
      add_item(-32'sd50, 1'b1);
      add_item(-32'sd45, 1'b1);
      add_item(-32'sd100, 1'b1);
      add_item(-32'sd91, 1'b0);
      add_item(-32'sd89, 1'b1);
      add_item(32'h7fff_ffff, 1'b1);
      add_item(32'h8000_0000, 1'b1);
      // wrapping hysteresis and always-post deadband
      add_cfg(REG_HYST, 32'h8000_0000);
      add_cfg(REG_VAL_DB, 32'hffff_ffff);
      add_cfg(REG_ARCH_DB, 32'h7fff_ffff);
      add_item(32'd100, 1'b1);
      add_item(32'h8000_0000, 1'b1);
      add_item(32'h7fff_ffff, 1'b0);
      add_cfg(REG_SEVMAP, 32'h3ff);
      add_item(32'd60, 1'b1);
      add_item(32'd0, 1'b1);

      send_idle_pct = 24;
      recv_idle_pct = 72;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) begin
            drain();
            write_reg(dir_rows[i].idx, dir_rows[i].value);
         end else begin
            send_reading(dir_rows[i].value, dir_rows[i].ok, dir_rows[i].typed,
                         dir_rows[i].want);
         end
      end

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin send_idle_pct = 24; recv_idle_pct = 72; end
            1: begin send_idle_pct = 72; recv_idle_pct = 24; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int set = 0; set < 5; set++) begin
            drain();
            pick_config((ph * 5 + set) % 3);
            repeat (50) send_reading(pick_reading(), 1'($urandom_range(1)), 1'b0, '0);
         end
      end

      drain();
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
